// ----- src/pms_pkg.sv -----
// Shared types and codes for the partitioned multi-stack block.
`default_nettype none

package pms_pkg;

  // Operation codes carried on the input request
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_LIST = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_POP_OUT,
    FSM_LIST_OUT
  } fsm_state_t;

  // Which result the output register is loaded with
  typedef enum logic [2:0] {
    OUT_RANGE,
    OUT_FULL,
    OUT_PUSH,
    OUT_EMPTY,
    OUT_POP,
    OUT_LIST
  } out_src_t;

  // Read address source for the item store
  typedef enum logic [1:0] {
    RD_POP,
    RD_LIST_FIRST,
    RD_LIST_NEXT
  } rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load_in;
    logic     load_out;
    out_src_t out_src;
    logic     push_wr;
    logic     pop_dec;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     idx_clr;
    logic     idx_inc;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic oor;
    logic full;
    logic empty;
    logic list_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/pms_ctrl.sv -----
// Controller state machine sequencing push, pop and list requests.
`default_nettype none

module pms_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire pms_pkg::stat_t stat,
  output pms_pkg::cmd_t       cmd
);

  pms_pkg::fsm_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pms_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd         = '0;
    cmd.out_src = pms_pkg::OUT_RANGE;
    cmd.rd_sel  = pms_pkg::RD_POP;
    case (state_r)
      pms_pkg::FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = pms_pkg::FSM_EXEC;
        end
      end
      pms_pkg::FSM_EXEC: begin
        if (stat.out_free) begin
          state_nxt = pms_pkg::FSM_IDLE;
          case (stat.op)
            pms_pkg::OP_PUSH: begin
              cmd.load_out = 1'b1;
              if (stat.oor) begin
                cmd.out_src = pms_pkg::OUT_RANGE;
              end else if (stat.full) begin
                cmd.out_src = pms_pkg::OUT_FULL;
              end else begin
                cmd.out_src = pms_pkg::OUT_PUSH;
                cmd.push_wr = 1'b1;
              end
            end
            pms_pkg::OP_POP: begin
              if (stat.oor) begin
                cmd.load_out = 1'b1;
                cmd.out_src  = pms_pkg::OUT_RANGE;
              end else if (stat.empty) begin
                cmd.load_out = 1'b1;
                cmd.out_src  = pms_pkg::OUT_EMPTY;
              end else begin
                // read the top entry while dropping the count
                cmd.pop_dec = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = pms_pkg::RD_POP;
                state_nxt   = pms_pkg::FSM_POP_OUT;
              end
            end
            pms_pkg::OP_LIST: begin
              if (stat.oor) begin
                cmd.load_out = 1'b1;
                cmd.out_src  = pms_pkg::OUT_RANGE;
              end else if (stat.empty) begin
                cmd.load_out = 1'b1;
                cmd.out_src  = pms_pkg::OUT_EMPTY;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = pms_pkg::RD_LIST_FIRST;
                cmd.idx_clr = 1'b1;
                state_nxt   = pms_pkg::FSM_LIST_OUT;
              end
            end
            default: begin
              // undefined operation: dropped without a result
              state_nxt = pms_pkg::FSM_IDLE;
            end
          endcase
        end
      end
      pms_pkg::FSM_POP_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_src  = pms_pkg::OUT_POP;
          state_nxt    = pms_pkg::FSM_IDLE;
        end
      end
      pms_pkg::FSM_LIST_OUT: begin
        // one entry per free output slot, next read issued alongside
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_src  = pms_pkg::OUT_LIST;
          if (stat.list_last) begin
            state_nxt = pms_pkg::FSM_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = pms_pkg::RD_LIST_NEXT;
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = pms_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/pms_dp.sv -----
// Datapath: request registers, top counts, item store and output register.
`default_nettype none

module pms_dp #(
  parameter int STACKS        = 2,
  parameter int TOTAL_ENTRIES = 16,
  parameter int ITEM_BITS     = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    in_op,
  input  wire logic          in_stack_sel,
  input  wire logic [31:0]   in_push_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_item_out,
  output logic [3:0]         out_fill_count,
  output logic               out_last,
  input  wire pms_pkg::cmd_t cmd,
  output pms_pkg::stat_t     stat
);

  localparam int REGION = TOTAL_ENTRIES / STACKS;
  localparam int CW     = (REGION > 0) ? $clog2(REGION + 1) : 1;
  localparam int SEL_W  = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int AW     = $clog2(TOTAL_ENTRIES);
  localparam int SW     = (ITEM_BITS < 32) ? ITEM_BITS : 32;

  // Latched request
  pms_pkg::op_t      op_r;
  logic              oor_r;
  logic [SEL_W-1:0]  sel_r;
  logic [SW-1:0]     item_r;

  // Per-stack top counts and list position
  logic [CW-1:0]     cnt_r [STACKS];
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     cur_cnt;

  // Item store
  logic [SW-1:0]     mem [TOTAL_ENTRIES];
  logic [SW-1:0]     rdata_r;
  logic [AW-1:0]     base;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  // Output register
  logic              valid_r;
  pms_pkg::status_t  status_r;
  logic [31:0]       item_out_r;
  logic [3:0]        fill_r;
  logic              last_r;
  logic              out_free;
  logic              list_last;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= pms_pkg::op_t'(in_op);
      oor_r  <= (32'(in_stack_sel) >= 32'(STACKS));
      sel_r  <= (32'(in_stack_sel) >= 32'(STACKS)) ? '0 : SEL_W'(in_stack_sel);
      item_r <= in_push_item[SW-1:0];
    end
  end

  // Region base and addresses
  assign cur_cnt   = cnt_r[sel_r];
  assign base      = AW'(sel_r) * AW'(REGION);
  assign wr_addr   = base + AW'(cur_cnt);
  assign list_last = (32'(idx_r) + 32'd1) == 32'(cur_cnt);

  always_comb begin
    case (cmd.rd_sel)
      pms_pkg::RD_POP:        rd_addr = base + AW'(cur_cnt - CW'(1));
      pms_pkg::RD_LIST_FIRST: rd_addr = base;
      pms_pkg::RD_LIST_NEXT:  rd_addr = base + AW'(idx_r + CW'(1));
      default:                rd_addr = base;
    endcase
  end

  // Top counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STACKS; s++) begin
        cnt_r[s] <= '0;
      end
    end else if (cmd.push_wr) begin
      cnt_r[sel_r] <= cur_cnt + CW'(1);
    end else if (cmd.pop_dec) begin
      cnt_r[sel_r] <= cur_cnt - CW'(1);
    end
  end

  // List position
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // Item store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[wr_addr] <= item_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Output register valid
  assign out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.out_src)
        pms_pkg::OUT_RANGE: begin
          status_r   <= pms_pkg::STAT_RANGE;
          item_out_r <= '0;
          fill_r     <= '0;
          last_r     <= 1'b1;
        end
        pms_pkg::OUT_FULL: begin
          status_r   <= pms_pkg::STAT_FULL;
          item_out_r <= '0;
          fill_r     <= 4'(REGION);
          last_r     <= 1'b1;
        end
        pms_pkg::OUT_PUSH: begin
          status_r   <= pms_pkg::STAT_OK;
          item_out_r <= '0;
          fill_r     <= 4'(cur_cnt + CW'(1));
          last_r     <= 1'b1;
        end
        pms_pkg::OUT_EMPTY: begin
          status_r   <= pms_pkg::STAT_EMPTY;
          item_out_r <= '0;
          fill_r     <= '0;
          last_r     <= 1'b1;
        end
        pms_pkg::OUT_POP: begin
          // count already holds the post-pop value
          status_r   <= pms_pkg::STAT_OK;
          item_out_r <= 32'(rdata_r);
          fill_r     <= 4'(cur_cnt);
          last_r     <= 1'b1;
        end
        pms_pkg::OUT_LIST: begin
          status_r   <= pms_pkg::STAT_OK;
          item_out_r <= 32'(rdata_r);
          fill_r     <= 4'(cur_cnt);
          last_r     <= list_last;
        end
        default: begin
          status_r   <= pms_pkg::STAT_RANGE;
          item_out_r <= '0;
          fill_r     <= '0;
          last_r     <= 1'b1;
        end
      endcase
    end
  end

  // Status back to the controller
  always_comb begin
    stat.op        = op_r;
    stat.oor       = oor_r;
    stat.full      = 32'(cur_cnt) >= 32'(REGION);
    stat.empty     = (cur_cnt == '0);
    stat.list_last = list_last;
    stat.out_free  = out_free;
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_item_out   = item_out_r;
  assign out_fill_count = fill_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

// ----- src/partitioned_multi_stack.sv -----
// Top level: several stacks sharing one item store, one region per stack.
// Sequence: a request is captured in idle; push, empty and out-of-range results are loaded
// from the execute state, a pop that removes an item reads the store there and loads its
// result from the pop-out state, and a list reads its first entry there, then gives one entry
// per cycle while the output is free. One request at a time; in_stall is low only in idle.
// Reset clears every top count (all stacks empty); the item store is not cleared.
`default_nettype none

module partitioned_multi_stack #(
  parameter int STACKS        = 2,
  parameter int TOTAL_ENTRIES = 16,
  parameter int ITEM_BITS     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic        in_stack_sel,
  input  wire logic [31:0] in_push_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_item_out,
  output logic [3:0]       out_fill_count,
  output logic             out_last
);

  pms_pkg::cmd_t  cmd;
  pms_pkg::stat_t stat;

  // Sequencer
  pms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path
  pms_dp #(
    .STACKS        (STACKS),
    .TOTAL_ENTRIES (TOTAL_ENTRIES),
    .ITEM_BITS     (ITEM_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_stack_sel   (in_stack_sel),
    .in_push_item   (in_push_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_item_out   (out_item_out),
    .out_fill_count (out_fill_count),
    .out_last       (out_last),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

`default_nettype wire
